// ===== hw/rtl/ramc_pkg.sv =====
// Package for the rational add/multiply/compare core.
// Holds operation codes, transaction payloads, sequencer states and divider control structs.
`default_nettype none
package ramc_pkg;
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_MUL = 2'd1,
        MODE_EQ  = 2'd2,
        MODE_NE  = 2'd3
    } mode_t;

    // Input transaction: two fractions with valid flags and an operation
    typedef struct packed {
        mode_t       mode;
        logic [15:0] a_num;
        logic [15:0] a_den;
        logic        a_ok;
        logic [15:0] b_num;
        logic [15:0] b_den;
        logic        b_ok;
    } frac_op_t;

    // Result transaction
    typedef struct packed {
        logic [32:0] res_num;
        logic [31:0] res_den;
        logic        res_ok;
        logic        cmp_true;
    } frac_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FORM,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_DIVN_START,
        ST_DIVN_WAIT,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_OUT
    } state_t;

    // Request and status between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ramc_if.sv =====
// Valid/ready channel interface for the rational core.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface ramc_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ramc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ramc_pkg for the control structs.
`default_nettype none
module ramc_div #(
    parameter int W = 34
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ramc_pkg::div_req_t req,
    input  wire logic [W-1:0]    dividend,
    input  wire logic [W-1:0]    divisor,
    output ramc_pkg::div_stat_t  stat,
    output logic [W-1:0]         quotient,
    output logic [W-1:0]         remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // One shift-subtract step per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        diff      = trial - {1'b0, d_reg};
        if (req.start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rational_add_mul_compare_core.sv =====
// Rational add/multiply/compare core: datapath, sequencer and shared divider.
// Depends on ramc_pkg, ramc_if and ramc_div.
`default_nettype none
// One transaction at a time. Three products are formed in turn through one
// shared multiplier; add/multiply then run Euclid's gcd on the shared divider
// (34 bits wide for 16-bit operands). Each remainder step starts the divider
// in GCD_START and waits in GCD_WAIT through its shift-subtract steps until
// the done flag. Two more divisions by the gcd follow, numerator then
// denominator, before the result is formed. A zero numerator skips the gcd
// and the divisions, compares skip the gcd and invalid operands go straight
// from the first product to the output. A result waits in the output register
// until taken; in is not ready meanwhile and returns the cycle after the
// result is taken.
module rational_add_mul_compare_core #(
    parameter int OPERAND_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    ramc_if.sink     in_ch,
    ramc_if.source   out_ch
);
    localparam int PW = 2 * OPERAND_BITS;
    localparam int W  = PW + 2;

    ramc_pkg::state_t state_reg, state_next;

    logic [1:0]              mode_reg;
    logic [OPERAND_BITS-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic                    ok_reg;
    logic [PW-1:0]           p0_reg, p1_reg, p2_reg;
    logic [W-1:0]            rn_reg, rd_reg, x_reg, y_reg;
    logic [32:0]             onum_reg;
    logic [31:0]             oden_reg;
    logic                    ook_reg, ocmp_reg;
    logic                    ovalid_reg;

    logic [OPERAND_BITS-1:0] in_an, in_ad, in_bn, in_bd;
    logic [OPERAND_BITS-1:0] m_a, m_b;
    logic [PW-1:0]           m_p;
    ramc_pkg::div_req_t      dreq;
    ramc_pkg::div_stat_t     dstat;
    logic [W-1:0]            d_dvd, d_dvs, d_q, d_r;

    // Operand fields sized to OPERAND_BITS
    assign in_an = OPERAND_BITS'(in_ch.data.a_num);
    assign in_ad = OPERAND_BITS'(in_ch.data.a_den);
    assign in_bn = OPERAND_BITS'(in_ch.data.b_num);
    assign in_bd = OPERAND_BITS'(in_ch.data.b_den);

    assign m_p = PW'(m_a) * PW'(m_b);

    ramc_div #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .dividend(d_dvd), .divisor(d_dvs),
        .stat(dstat), .quotient(d_q), .remainder(d_r)
    );

    assign in_ch.ready  = (state_reg == ramc_pkg::ST_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = {onum_reg, oden_reg, ook_reg, ocmp_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ramc_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready) state_next = ramc_pkg::ST_MUL0;
            ramc_pkg::ST_MUL0:
                state_next = ok_reg ? ramc_pkg::ST_MUL1 : ramc_pkg::ST_OUT;
            ramc_pkg::ST_MUL1: state_next = ramc_pkg::ST_MUL2;
            ramc_pkg::ST_MUL2: state_next = ramc_pkg::ST_FORM;
            ramc_pkg::ST_FORM:
                if (mode_reg == ramc_pkg::MODE_EQ || mode_reg == ramc_pkg::MODE_NE)
                    state_next = ramc_pkg::ST_OUT;
                else
                    state_next = ramc_pkg::ST_GCD_START;
            ramc_pkg::ST_GCD_START:
                if (rn_reg == '0 || y_reg == '0) state_next = ramc_pkg::ST_OUT;
                else if (y_reg == '0) state_next = ramc_pkg::ST_DIVN_START;
                else state_next = ramc_pkg::ST_GCD_WAIT;
            ramc_pkg::ST_GCD_WAIT:
                if (dstat.done)
                    state_next = (d_r == '0) ? ramc_pkg::ST_DIVN_START
                                             : ramc_pkg::ST_GCD_START;
            ramc_pkg::ST_DIVN_START: state_next = ramc_pkg::ST_DIVN_WAIT;
            ramc_pkg::ST_DIVN_WAIT:
                if (dstat.done) state_next = ramc_pkg::ST_DIVD_START;
            ramc_pkg::ST_DIVD_START: state_next = ramc_pkg::ST_DIVD_WAIT;
            ramc_pkg::ST_DIVD_WAIT:
                if (dstat.done) state_next = ramc_pkg::ST_OUT;
            ramc_pkg::ST_OUT: state_next = ramc_pkg::ST_IDLE;
            default: state_next = ramc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and divider control
    always_comb
    begin
        m_a        = an_reg;
        m_b        = bd_reg;
        dreq.start = 1'b0;
        d_dvd      = x_reg;
        d_dvs      = y_reg;
        case (state_reg)
            ramc_pkg::ST_MUL0: begin m_a = an_reg; m_b = bd_reg; end
            ramc_pkg::ST_MUL1:
            begin
                // multiply needs an*bn, the others ad*bn
                m_a = (mode_reg == ramc_pkg::MODE_MUL) ? an_reg : ad_reg;
                m_b = bn_reg;
            end
            ramc_pkg::ST_MUL2: begin m_a = ad_reg; m_b = bd_reg; end
            ramc_pkg::ST_GCD_START:
                dreq.start = (rn_reg != '0) && (y_reg != '0);
            ramc_pkg::ST_DIVN_START:
            begin
                dreq.start = 1'b1;
                d_dvd      = rn_reg;
            end
            ramc_pkg::ST_DIVD_START:
            begin
                dreq.start = 1'b1;
                d_dvd      = rd_reg;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ramc_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ramc_pkg::ST_OUT) ovalid_reg <= 1'b1;
            else if (out_ch.ready) ovalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ramc_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    mode_reg <= in_ch.data.mode;
                    an_reg   <= in_an;
                    ad_reg   <= in_ad;
                    bn_reg   <= in_bn;
                    bd_reg   <= in_bd;
                    ok_reg   <= in_ch.data.a_ok && in_ch.data.b_ok
                                && (in_ad != '0) && (in_bd != '0);
                    rn_reg   <= '0;
                    rd_reg   <= '0;
                end
            ramc_pkg::ST_MUL0: p0_reg <= m_p;
            ramc_pkg::ST_MUL1: p1_reg <= m_p;
            ramc_pkg::ST_MUL2: p2_reg <= m_p;
            ramc_pkg::ST_FORM:
            begin
                if (mode_reg == ramc_pkg::MODE_ADD)
                    rn_reg <= W'(p0_reg) + W'(p1_reg);
                else
                    rn_reg <= W'(p1_reg);
                rd_reg <= W'(p2_reg);
                if (mode_reg == ramc_pkg::MODE_ADD)
                    x_reg <= W'(p0_reg) + W'(p1_reg);
                else
                    x_reg <= W'(p1_reg);
                y_reg <= W'(p2_reg);
            end
            ramc_pkg::ST_GCD_WAIT:
                if (dstat.done)
                begin
                    if (d_r == '0) y_reg <= y_reg;
                    else
                    begin
                        x_reg <= y_reg;
                        y_reg <= d_r;
                    end
                end
            ramc_pkg::ST_DIVN_WAIT:
                if (dstat.done) rn_reg <= d_q;
            ramc_pkg::ST_DIVD_WAIT:
                if (dstat.done) rd_reg <= d_q;
            ramc_pkg::ST_OUT:
            begin
                ook_reg <= ok_reg;
                if (ok_reg && (mode_reg == ramc_pkg::MODE_ADD
                               || mode_reg == ramc_pkg::MODE_MUL))
                begin
                    onum_reg <= 33'(rn_reg);
                    oden_reg <= 32'(rd_reg);
                end
                else
                begin
                    onum_reg <= '0;
                    oden_reg <= '0;
                end
                ocmp_reg <= ok_reg && (
                    (mode_reg == ramc_pkg::MODE_EQ && p0_reg == p1_reg) ||
                    (mode_reg == ramc_pkg::MODE_NE && p0_reg != p1_reg));
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ramc_checker.sv =====
// Port-level checker for the rational core, bound to the top level.
// Depends on ramc_if only through the bound ports.
`default_nettype none
module ramc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic res_ok,
    input wire logic cmp_true,
    input wire logic [31:0] res_den
);
    // No new transaction while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready with result pending");
    // Accepting stops readiness next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(res_den))
        else $error("stalled result changed");
    // Invalid result carries zeros
    a_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !res_ok) |-> (!cmp_true && res_den == 32'd0))
        else $error("invalid result not cleared");
endmodule

bind rational_add_mul_compare_core ramc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .res_ok(out_ch.data.res_ok), .cmp_true(out_ch.data.cmp_true),
    .res_den(out_ch.data.res_den)
);
`default_nettype wire

// ===== tb/rational_add_mul_compare_core_tb.sv =====
// Testbench for the rational add/multiply/compare core.
// Depends on ramc_pkg, ramc_if and rational_add_mul_compare_core.
`default_nettype none
module rational_add_mul_compare_core_tb;
    localparam int OPERAND_BITS = 16;
    localparam int N_RANDOM     = 625;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // Expected results of the fraction core, one per operation
    class frac_scoreboard;
        ramc_pkg::frac_res_t expected_q[$];
        int                  mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function bit [63:0] euclid(bit [63:0] x, bit [63:0] y);
            bit [63:0] r;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        static function ramc_pkg::frac_res_t compute(ramc_pkg::frac_op_t op);
            bit [63:0]           opmask;
            bit [63:0]           an, ad, bn, bd, rn, rd, g;
            bit                  ok, same;
            ramc_pkg::frac_res_t res;
            opmask = (64'd1 << OPERAND_BITS) - 1;
            an = op.a_num & opmask;
            ad = op.a_den & opmask;
            bn = op.b_num & opmask;
            bd = op.b_den & opmask;
            ok = op.a_ok && ad != 0 && op.b_ok && bd != 0;
            res = '0;
            res.res_ok = ok;
            if (ok)
            begin
                if (op.mode == ramc_pkg::MODE_ADD || op.mode == ramc_pkg::MODE_MUL)
                begin
                    rn = (op.mode == ramc_pkg::MODE_ADD) ? an * bd + ad * bn : an * bn;
                    rd = ad * bd;
                    // zero numerator: no reduction, the denominator stays ad*bd
                    if (rn != 0)
                    begin
                        g = euclid(rn, rd);
                        rn = rn / g;
                        rd = rd / g;
                    end
                    res.res_num = rn[32:0];
                    res.res_den = rd[31:0];
                end
                else
                begin
                    same = (an * bd) == (ad * bn);
                    res.cmp_true = (op.mode == ramc_pkg::MODE_EQ) ? same : !same;
                end
            end
            return res;
        endfunction

        function void note_op(ramc_pkg::frac_op_t op);
            expected_q.push_back(compute(op));
        endfunction

        function void check_result(ramc_pkg::frac_res_t got);
            ramc_pkg::frac_res_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: num=%0d den=%0d ok=%0b cmp=%0b",
                             got.res_num, got.res_den, got.res_ok, got.cmp_true);
                return;
            end
            exp = expected_q.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: exp num=%0d den=%0d ok=%0b cmp=%0b,",
                              " got num=%0d den=%0d ok=%0b cmp=%0b"},
                             exp.res_num, exp.res_den, exp.res_ok, exp.cmp_true,
                             got.res_num, got.res_den, got.res_ok, got.cmp_true);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ramc_if #(.payload_t(ramc_pkg::frac_op_t))  in_ch (clk);
    ramc_if #(.payload_t(ramc_pkg::frac_res_t)) out_ch (clk);

    rational_add_mul_compare_core #(.OPERAND_BITS(OPERAND_BITS)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    frac_scoreboard sb = new();
    bit             no_gaps;
    bit             hold_request;
    bit             hold_done;
    int             idle_cycles = 0;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Transaction monitors
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            sb.note_op(in_ch.data);
        if (out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("rational_add_mul_compare_core_tb: FAIL");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            w = no_gaps ? 0 : $urandom_range(0, 13);
            if (w > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Drive one operation, called at a falling edge, returns at a falling edge
    task automatic send_op(ramc_pkg::frac_op_t op);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= op;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge clk);
    endtask

    function automatic ramc_pkg::frac_op_t make_op(ramc_pkg::mode_t m, int an, int ad,
                                                   bit ao, int bn, int bd, bit bo);
        ramc_pkg::frac_op_t op;
        op.mode  = m;
        op.a_num = an[15:0];
        op.a_den = ad[15:0];
        op.a_ok  = ao;
        op.b_num = bn[15:0];
        op.b_den = bd[15:0];
        op.b_ok  = bo;
        return op;
    endfunction

    // Mixed magnitudes so that both tiny and full-width values appear
    function automatic logic [15:0] rand_val(bit allow_zero);
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 15));
            1: v = 16'($urandom_range(0, 255));
            default: v = 16'($urandom);
        endcase
        if (!allow_zero && v == 0)
            v = 16'd1;
        return v;
    endfunction

    function automatic ramc_pkg::frac_op_t rand_op();
        ramc_pkg::frac_op_t op;
        int                 k;
        op.mode  = ramc_pkg::mode_t'($urandom_range(0, 3));
        op.a_num = ($urandom_range(0, 9) == 0) ? 16'd0 : rand_val(1'b1);
        op.a_den = rand_val(1'b0);
        op.b_num = ($urandom_range(0, 9) == 0) ? 16'd0 : rand_val(1'b1);
        op.b_den = rand_val(1'b0);
        op.a_ok  = 1'b1;
        op.b_ok  = 1'b1;
        // equal fractions now and then so compares come out true
        if ($urandom_range(0, 5) == 0)
        begin
            k = $urandom_range(1, 7);
            op.b_num = 16'(op.a_num * k);
            op.b_den = 16'(op.a_den * k);
            if (op.b_den == 0)
                op.b_den = op.a_den;
        end
        // broken operands: cleared flag or zero denominator
        k = $urandom_range(0, 19);
        if (k == 0)
            op.a_ok = 1'b0;
        else if (k == 1)
            op.b_ok = 1'b0;
        else if (k == 2)
            op.a_den = 16'd0;
        else if (k == 3)
            op.b_den = 16'd0;
        return op;
    endfunction

    initial
    begin
        ramc_pkg::frac_op_t ops[$];
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every mode, extremes, invalid and zero cases
        for (int m = 0; m < 4; m++)
        begin
            ops.push_back(make_op(ramc_pkg::mode_t'(m), 65535, 65535, 1, 65535, 65535, 1));
            ops.push_back(make_op(ramc_pkg::mode_t'(m), 65535, 1, 1, 65535, 1, 1));
            ops.push_back(make_op(ramc_pkg::mode_t'(m), 0, 65535, 1, 0, 1, 1));
            ops.push_back(make_op(ramc_pkg::mode_t'(m), 3, 4, 1, 6, 8, 1));
            ops.push_back(make_op(ramc_pkg::mode_t'(m), 5, 7, 0, 2, 3, 1));
        end
        ops.push_back(make_op(ramc_pkg::MODE_ADD, 1, 0, 1, 2, 3, 1));
        ops.push_back(make_op(ramc_pkg::MODE_MUL, 1, 2, 1, 2, 0, 1));
        ops.push_back(make_op(ramc_pkg::MODE_EQ, 1, 2, 1, 1, 2, 0));
        ops.push_back(make_op(ramc_pkg::MODE_NE, 0, 0, 0, 0, 0, 0));
        ops.push_back(make_op(ramc_pkg::MODE_MUL, 0, 5, 1, 7, 9, 1));
        foreach (ops[i])
            send_op(ops[i]);

        // Random part
        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_gaps = (i >= 150 && i < 230);
            if (i == 300)
                hold_request = 1'b1;
            // let the pipeline drain completely once
            if (i == 450)
            begin
                in_ch.valid <= 1'b0;
                while (sb.expected_q.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            send_op(rand_op());
        end
        in_ch.valid <= 1'b0;
        no_gaps = 1'b0;

        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("rational_add_mul_compare_core_tb: PASS");
        else
            $display("rational_add_mul_compare_core_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/ramc_pkg.sv
hw/rtl/ramc_if.sv
hw/rtl/ramc_div.sv
hw/rtl/rational_add_mul_compare_core.sv
hw/rtl/ramc_checker.sv
tb/rational_add_mul_compare_core_tb.sv
